FILE: sv/lpg_pkg.sv
`default_nettype none

package lpg_pkg;

  localparam int DEF_COORD_BITS = 10;
  localparam int SIZE_W         = 11;
  localparam int COLOUR_W       = 16;
  localparam int CFG_IDX_W      = 8;

  localparam logic [SIZE_W-1:0] RESET_SCREEN_WIDTH  = SIZE_W'(240);
  localparam logic [SIZE_W-1:0] RESET_SCREEN_HEIGHT = SIZE_W'(320);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCREEN_WIDTH  = 8'd0,
    REG_SCREEN_HEIGHT = 8'd1
  } cfg_reg_e;

endpackage

`default_nettype wire

FILE: sv/lpg_prep.sv
`default_nettype none

module lpg_prep import lpg_pkg::*; #(
  parameter int CoordBits = DEF_COORD_BITS
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   valid_i,
  input  wire logic [SIZE_W-1:0]      screen_width_i,
  input  wire logic [SIZE_W-1:0]      screen_height_i,
  input  wire logic [CoordBits-1:0]   start_x_i,
  input  wire logic [CoordBits-1:0]   start_y_i,
  input  wire logic [CoordBits-1:0]   end_x_i,
  input  wire logic [CoordBits-1:0]   end_y_i,
  input  wire logic [CoordBits-1:0]   step_index_i,
  input  wire logic [COLOUR_W-1:0]    pixel_colour_i,
  output logic                        valid_o,
  output logic [2*CoordBits-1:0]      dividend_o,
  output logic [CoordBits-1:0]        divisor_o,
  output logic [COLOUR_W-1:0]         colour_o,
  output logic [CoordBits:0]          count_o,
  output logic                        in_range_o,
  output logic                        is_last_o,
  output logic [CoordBits-1:0]        major_o,
  output logic [CoordBits-1:0]        min_a_o,
  output logic                        neg_o,
  output logic                        y_major_o,
  output logic                        zero_o
);

  localparam int CW = (CoordBits > SIZE_W) ? CoordBits : SIZE_W;

  function automatic logic [CoordBits-1:0] clamp(input logic [CoordBits-1:0] v,
                                                 input logic [SIZE_W-1:0] size);
    logic [CW-1:0] s;
    logic [CW-1:0] ve;
    s = (size == '0) ? CW'(1) : CW'(size);
    ve = CW'(v);
    clamp = (ve >= s) ? CoordBits'(s - CW'(1)) : v;
  endfunction

  // clamp
  logic                   a_valid_q;
  logic [CoordBits-1:0]   a_x0_q, a_y0_q, a_x1_q, a_y1_q, a_step_q;
  logic [COLOUR_W-1:0]    a_colour_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else begin
      a_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    a_x0_q     <= clamp(start_x_i, screen_width_i);
    a_y0_q     <= clamp(start_y_i, screen_height_i);
    a_x1_q     <= clamp(end_x_i, screen_width_i);
    a_y1_q     <= clamp(end_y_i, screen_height_i);
    a_step_q   <= step_index_i;
    a_colour_q <= pixel_colour_i;
  end

  // order along the major axis
  logic [CoordBits-1:0] dx, dy, dmaj_d, dmin_d, maj_a_d, min_a_d, min_b_d;
  logic                 ymaj_d, swap;

  always_comb begin
    dx     = (a_x1_q >= a_x0_q) ? (a_x1_q - a_x0_q) : (a_x0_q - a_x1_q);
    dy     = (a_y1_q >= a_y0_q) ? (a_y1_q - a_y0_q) : (a_y0_q - a_y1_q);
    ymaj_d = dx < dy;
    swap   = ymaj_d ? (a_y0_q > a_y1_q) : (a_x0_q > a_x1_q);
    dmaj_d = ymaj_d ? dy : dx;
    dmin_d = ymaj_d ? dx : dy;
    if (ymaj_d) begin
      maj_a_d = swap ? a_y1_q : a_y0_q;
      min_a_d = swap ? a_x1_q : a_x0_q;
      min_b_d = swap ? a_x0_q : a_x1_q;
    end else begin
      maj_a_d = swap ? a_x1_q : a_x0_q;
      min_a_d = swap ? a_y1_q : a_y0_q;
      min_b_d = swap ? a_y0_q : a_y1_q;
    end
  end

  logic                   b_valid_q, b_ymaj_q;
  logic [CoordBits-1:0]   b_dmaj_q, b_dmin_q, b_maj_a_q, b_min_a_q, b_min_b_q, b_step_q;
  logic [COLOUR_W-1:0]    b_colour_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    b_ymaj_q   <= ymaj_d;
    b_dmaj_q   <= dmaj_d;
    b_dmin_q   <= dmin_d;
    b_maj_a_q  <= maj_a_d;
    b_min_a_q  <= min_a_d;
    b_min_b_q  <= min_b_d;
    b_step_q   <= a_step_q;
    b_colour_q <= a_colour_q;
  end

  // multiply and flags
  logic c_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
    end else begin
      c_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    dividend_o <= (2*CoordBits)'(b_dmin_q) * (2*CoordBits)'(b_step_q);
    divisor_o  <= b_dmaj_q;
    colour_o   <= b_colour_q;
    count_o    <= {1'b0, b_dmaj_q} + (CoordBits+1)'(1);
    in_range_o <= b_step_q <= b_dmaj_q;
    is_last_o  <= b_step_q == b_dmaj_q;
    major_o    <= b_maj_a_q + b_step_q;
    min_a_o    <= b_min_a_q;
    neg_o      <= b_min_a_q > b_min_b_q;
    y_major_o  <= b_ymaj_q;
    zero_o     <= b_dmaj_q == '0;
  end

  assign valid_o = c_valid_q;

endmodule

`default_nettype wire

FILE: sv/lpg_div_stage.sv
`default_nettype none

module lpg_div_stage import lpg_pkg::*; #(
  parameter int CoordBits = DEF_COORD_BITS,
  parameter int Shift     = 0,
  parameter int SideW     = 1
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   valid_i,
  input  wire logic [2*CoordBits-1:0] rem_i,
  input  wire logic [CoordBits-1:0]   divisor_i,
  input  wire logic [CoordBits-1:0]   quot_i,
  input  wire logic [SideW-1:0]       side_i,
  output logic                        valid_o,
  output logic [2*CoordBits-1:0]      rem_o,
  output logic [CoordBits-1:0]        divisor_o,
  output logic [CoordBits-1:0]        quot_o,
  output logic [SideW-1:0]            side_o
);

  logic [2*CoordBits-1:0] trial;
  logic                   take;
  logic                   valid_q;

  assign trial = (2*CoordBits)'(divisor_i) << Shift;
  assign take  = rem_i >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_o     <= take ? (rem_i - trial) : rem_i;
    quot_o    <= quot_i | (take ? (CoordBits'(1) << Shift) : '0);
    divisor_o <= divisor_i;
    side_o    <= side_i;
  end

  assign valid_o = valid_q;

endmodule

`default_nettype wire

FILE: sv/line_point_generator_top.sv
`default_nettype none

// Line point generator: returns one point of a clamped straight line per word,
// with colour, point count and range flags. A word is taken in every cycle
// (busy_o stays low). Its result passes three stages of clamping, ordering and
// multiplying, the slope divider and the output register, then shows for one
// cycle on point_valid_o; the receiver cannot stall it. The divider resolves
// one quotient bit per pipeline stage. Screen size writes are always ready
// and must only be made while no word is in flight.

module line_point_generator_top import lpg_pkg::*; #(
  parameter int COORD_BITS = DEF_COORD_BITS
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start_i,
  output logic                         busy_o,
  input  wire logic [COORD_BITS-1:0]   start_x_i,
  input  wire logic [COORD_BITS-1:0]   start_y_i,
  input  wire logic [COORD_BITS-1:0]   end_x_i,
  input  wire logic [COORD_BITS-1:0]   end_y_i,
  input  wire logic [COORD_BITS-1:0]   step_index_i,
  input  wire logic [COLOUR_W-1:0]     pixel_colour_i,
  output logic                         point_valid_o,
  output logic [COORD_BITS-1:0]        point_x_o,
  output logic [COORD_BITS-1:0]        point_y_o,
  output logic [COLOUR_W-1:0]          point_colour_o,
  output logic [COORD_BITS:0]          point_count_o,
  output logic                         in_range_o,
  output logic                         is_last_o,
  input  wire logic                    cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [SIZE_W-1:0]       cfg_data_i
);

  localparam int CB    = COORD_BITS;
  localparam int SIDEW = COLOUR_W + (CB + 1) + 2 + 2 * CB + 3;

  logic [SIZE_W-1:0] width_q, height_q;

  assign cfg_ready_o = 1'b1;
  assign busy_o      = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= RESET_SCREEN_WIDTH;
      height_q <= RESET_SCREEN_HEIGHT;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_SCREEN_WIDTH:  width_q  <= cfg_data_i;
        REG_SCREEN_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic                 p_valid, p_inr, p_last, p_neg, p_ymaj, p_zero;
  logic [2*CB-1:0]      p_dividend;
  logic [CB-1:0]        p_divisor, p_major, p_min_a;
  logic [COLOUR_W-1:0]  p_colour;
  logic [CB:0]          p_count;

  lpg_prep #(.CoordBits(CB)) u_prep (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (start_i),
    .screen_width_i  (width_q),
    .screen_height_i (height_q),
    .start_x_i       (start_x_i),
    .start_y_i       (start_y_i),
    .end_x_i         (end_x_i),
    .end_y_i         (end_y_i),
    .step_index_i    (step_index_i),
    .pixel_colour_i  (pixel_colour_i),
    .valid_o         (p_valid),
    .dividend_o      (p_dividend),
    .divisor_o       (p_divisor),
    .colour_o        (p_colour),
    .count_o         (p_count),
    .in_range_o      (p_inr),
    .is_last_o       (p_last),
    .major_o         (p_major),
    .min_a_o         (p_min_a),
    .neg_o           (p_neg),
    .y_major_o       (p_ymaj),
    .zero_o          (p_zero)
  );

  logic              dv_valid [CB+1];
  logic [2*CB-1:0]   dv_rem   [CB+1];
  logic [CB-1:0]     dv_div   [CB+1];
  logic [CB-1:0]     dv_quot  [CB+1];
  logic [SIDEW-1:0]  dv_side  [CB+1];

  assign dv_valid[0] = p_valid;
  assign dv_rem[0]   = p_dividend;
  assign dv_div[0]   = p_divisor;
  assign dv_quot[0]  = '0;
  assign dv_side[0]  = {p_colour, p_count, p_inr, p_last, p_major, p_min_a,
                        p_neg, p_ymaj, p_zero};

  for (genvar g = 0; g < CB; g++) begin : g_div
    lpg_div_stage #(
      .CoordBits (CB),
      .Shift     (CB - 1 - g),
      .SideW     (SIDEW)
    ) u_stage (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .valid_i   (dv_valid[g]),
      .rem_i     (dv_rem[g]),
      .divisor_i (dv_div[g]),
      .quot_i    (dv_quot[g]),
      .side_i    (dv_side[g]),
      .valid_o   (dv_valid[g+1]),
      .rem_o     (dv_rem[g+1]),
      .divisor_o (dv_div[g+1]),
      .quot_o    (dv_quot[g+1]),
      .side_o    (dv_side[g+1])
    );
  end

  logic                 e_inr, e_last, e_neg, e_ymaj, e_zero;
  logic [CB-1:0]        e_major, e_min_a, off, minor;
  logic [COLOUR_W-1:0]  e_colour;
  logic [CB:0]          e_count;

  assign {e_colour, e_count, e_inr, e_last, e_major, e_min_a, e_neg, e_ymaj, e_zero} =
      dv_side[CB];

  assign off   = e_zero ? '0 : dv_quot[CB];
  assign minor = e_neg ? (e_min_a - off) : (e_min_a + off);

  logic               out_valid_q;
  logic [CB-1:0]      px_d, py_d;

  always_comb begin
    px_d = '0;
    py_d = '0;
    if (e_inr) begin
      px_d = e_ymaj ? minor : e_major;
      py_d = e_ymaj ? e_major : minor;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= dv_valid[CB];
    end
  end

  always_ff @(posedge clk_i) begin
    point_x_o      <= px_d;
    point_y_o      <= py_d;
    point_colour_o <= e_colour;
    point_count_o  <= e_count;
    in_range_o     <= e_inr;
    is_last_o      <= e_last;
  end

  assign point_valid_o = out_valid_q;

endmodule

`default_nettype wire

FILE: tb/line_point_checker.sv
`timescale 1ns / 100ps

module line_point_checker import lpg_pkg::*; #(
  parameter int COORD_BITS = DEF_COORD_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic                  busy_i,
  input  logic [COORD_BITS-1:0] start_x_i,
  input  logic [COORD_BITS-1:0] start_y_i,
  input  logic [COORD_BITS-1:0] end_x_i,
  input  logic [COORD_BITS-1:0] end_y_i,
  input  logic [COORD_BITS-1:0] step_index_i,
  input  logic [COLOUR_W-1:0]   pixel_colour_i,
  input  logic                  point_valid_i,
  input  logic [COORD_BITS-1:0] point_x_i,
  input  logic [COORD_BITS-1:0] point_y_i,
  input  logic [COLOUR_W-1:0]   point_colour_i,
  input  logic [COORD_BITS:0]   point_count_i,
  input  logic                  in_range_i,
  input  logic                  is_last_i,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [SIZE_W-1:0]     cfg_data_i,
  output int                    fail_count_o,
  output int                    pending_o,
  output int                    checked_o
);

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [COLOUR_W-1:0]   colour;
    logic [COORD_BITS:0]   count;
    logic                  in_range;
    logic                  last;
  } point_t;

  point_t            expected_points_q[$];
  logic [SIZE_W-1:0] screen_w;
  logic [SIZE_W-1:0] screen_h;

  function automatic int clip(input int v, input int size);
    int lim;
    lim = (size == 0) ? 1 : size;
    return (v >= lim) ? lim - 1 : v;
  endfunction

  function automatic point_t predict_point(
    input logic [COORD_BITS-1:0] sx,
    input logic [COORD_BITS-1:0] sy,
    input logic [COORD_BITS-1:0] ex,
    input logic [COORD_BITS-1:0] ey,
    input logic [COORD_BITS-1:0] step,
    input logic [COLOUR_W-1:0]   colour
  );
    int     x0, y0, x1, y1, dx, dy;
    int     maj_a, maj_b, min_a, min_b, dmaj, dmin, tmp, offs, major, minor;
    bit     y_major;
    point_t p;
    x0 = clip(sx, screen_w);
    y0 = clip(sy, screen_h);
    x1 = clip(ex, screen_w);
    y1 = clip(ey, screen_h);
    dx = (x1 >= x0) ? x1 - x0 : x0 - x1;
    dy = (y1 >= y0) ? y1 - y0 : y0 - y1;
    y_major = dx < dy;
    maj_a = y_major ? y0 : x0;
    min_a = y_major ? x0 : y0;
    maj_b = y_major ? y1 : x1;
    min_b = y_major ? x1 : y1;
    dmaj  = y_major ? dy : dx;
    dmin  = y_major ? dx : dy;
    // order along the major axis, lower end first
    if (maj_a > maj_b) begin
      tmp = maj_a; maj_a = maj_b; maj_b = tmp;
      tmp = min_a; min_a = min_b; min_b = tmp;
    end
    p.colour   = colour;
    p.count    = (COORD_BITS+1)'(dmaj + 1);
    p.in_range = int'(step) < dmaj + 1;
    p.last     = int'(step) == dmaj;
    p.x        = '0;
    p.y        = '0;
    if (p.in_range) begin
      major = maj_a + int'(step);
      offs  = (dmaj != 0) ? (dmin * int'(step)) / dmaj : 0;
      minor = (min_a > min_b) ? min_a - offs : min_a + offs;
      p.x   = COORD_BITS'(y_major ? minor : major);
      p.y   = COORD_BITS'(y_major ? major : minor);
    end
    return p;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      fail_count_o++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    point_t want;
    if (!rst_ni) begin
      screen_w = RESET_SCREEN_WIDTH;
      screen_h = RESET_SCREEN_HEIGHT;
      expected_points_q.delete();
      pending_o = 0;
    end else begin
      if (point_valid_i) begin
        if (expected_points_q.size() == 0) begin
          fail_count_o++;
          $display("%0t: point with no word outstanding, expected none, got x %0d y %0d",
                   $time, point_x_i, point_y_i);
        end else begin
          want = expected_points_q.pop_front();
          check_field("point_x", want.x, point_x_i);
          check_field("point_y", want.y, point_y_i);
          check_field("point_colour", want.colour, point_colour_i);
          check_field("point_count", want.count, point_count_i);
          check_field("in_range", want.in_range, in_range_i);
          check_field("is_last", want.last, is_last_i);
          checked_o++;
        end
      end
      if (start_i && !busy_i)
        expected_points_q.push_back(predict_point(start_x_i, start_y_i, end_x_i, end_y_i,
                                                  step_index_i, pixel_colour_i));
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == REG_SCREEN_WIDTH)
          screen_w = cfg_data_i;
        else if (cfg_index_i == REG_SCREEN_HEIGHT)
          screen_h = cfg_data_i;
      end
      pending_o = expected_points_q.size();
    end
  end

endmodule

FILE: tb/tb_line_point_generator_top.sv
`timescale 1ns / 100ps

module tb_line_point_generator_top import lpg_pkg::*;;

  localparam int CB          = DEF_COORD_BITS;
  localparam int MAX_COORD   = (1 << CB) - 1;
  localparam int LATENCY     = CB + 4;
  localparam int PHASES      = 8;
  localparam int PHASE_WORDS = 220;

  localparam logic [CFG_IDX_W-1:0] SPARE_REG_IDX = '1;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 start_i;
  logic                 busy_o;
  logic [CB-1:0]        start_x_i;
  logic [CB-1:0]        start_y_i;
  logic [CB-1:0]        end_x_i;
  logic [CB-1:0]        end_y_i;
  logic [CB-1:0]        step_index_i;
  logic [COLOUR_W-1:0]  pixel_colour_i;
  logic                 point_valid_o;
  logic [CB-1:0]        point_x_o;
  logic [CB-1:0]        point_y_o;
  logic [COLOUR_W-1:0]  point_colour_o;
  logic [CB:0]          point_count_o;
  logic                 in_range_o;
  logic                 is_last_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [SIZE_W-1:0]    cfg_data_i;

  int fail_count;
  int pending_words;
  int checked_points;
  int words_sent;
  int settings_used;
  int idle_pct;
  int cur_w;
  int cur_h;

  int width_plan[PHASES]  = '{1024, 1, 0, 2047, 640, 0, 320, 1024};
  int height_plan[PHASES] = '{1024, 1, 0, 1500, 480, 0, 240, 1};

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  line_point_generator_top #(
    .COORD_BITS(CB)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .start_x_i     (start_x_i),
    .start_y_i     (start_y_i),
    .end_x_i       (end_x_i),
    .end_y_i       (end_y_i),
    .step_index_i  (step_index_i),
    .pixel_colour_i(pixel_colour_i),
    .point_valid_o (point_valid_o),
    .point_x_o     (point_x_o),
    .point_y_o     (point_y_o),
    .point_colour_o(point_colour_o),
    .point_count_o (point_count_o),
    .in_range_o    (in_range_o),
    .is_last_o     (is_last_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  line_point_checker #(
    .COORD_BITS(CB)
  ) point_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_i        (busy_o),
    .start_x_i     (start_x_i),
    .start_y_i     (start_y_i),
    .end_x_i       (end_x_i),
    .end_y_i       (end_y_i),
    .step_index_i  (step_index_i),
    .pixel_colour_i(pixel_colour_i),
    .point_valid_i (point_valid_o),
    .point_x_i     (point_x_o),
    .point_y_i     (point_y_o),
    .point_colour_i(point_colour_o),
    .point_count_i (point_count_o),
    .in_range_i    (in_range_o),
    .is_last_i     (is_last_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .fail_count_o  (fail_count),
    .pending_o     (pending_words),
    .checked_o     (checked_points)
  );

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    cfg_index_i <= idx;
    cfg_data_i  <= SIZE_W'(value);
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic set_screen(input int w, input int h, input bit spare);
    write_reg(REG_SCREEN_WIDTH, w);
    write_reg(REG_SCREEN_HEIGHT, h);
    if (spare)
      write_reg(SPARE_REG_IDX, $urandom_range(2047));
    cfg_valid_i <= 1'b0;
    cur_w = w;
    cur_h = h;
    settings_used++;
  endtask

  task automatic drive_word(input int sx, input int sy, input int ex, input int ey,
                            input int step, input int colour);
    if ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    start_x_i      <= CB'(sx);
    start_y_i      <= CB'(sy);
    end_x_i        <= CB'(ex);
    end_y_i        <= CB'(ey);
    step_index_i   <= CB'(step);
    pixel_colour_i <= COLOUR_W'(colour);
    start_i        <= 1'b1;
    do @(posedge clk_i); while (busy_o);
    words_sent++;
  endtask

  task automatic drain();
    start_i <= 1'b0;
    do @(negedge clk_i); while (pending_words != 0);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  function automatic int screen_lim(input int size);
    if (size == 0)
      return 1;
    return (size > MAX_COORD + 1) ? MAX_COORD + 1 : size;
  endfunction

  function automatic int near(input int v, input int lim);
    int n;
    n = v + int'($urandom_range(6)) - 3;
    if (n < 0)
      n = 0;
    if (n > lim - 1)
      n = lim - 1;
    return n;
  endfunction

  // mostly on-screen lines with in-range steps; the rest clamped noise and stray steps
  task automatic random_word();
    int lim_w, lim_h, sx, sy, ex, ey, span, step, pick;
    lim_w = screen_lim(cur_w);
    lim_h = screen_lim(cur_h);
    if ($urandom_range(99) < 85) begin
      sx = $urandom_range(lim_w - 1);
      sy = $urandom_range(lim_h - 1);
      if ($urandom_range(3) == 0) begin
        ex = near(sx, lim_w);
        ey = near(sy, lim_h);
      end else begin
        ex = $urandom_range(lim_w - 1);
        ey = $urandom_range(lim_h - 1);
      end
    end else begin
      sx = $urandom_range(MAX_COORD);
      sy = $urandom_range(MAX_COORD);
      ex = $urandom_range(MAX_COORD);
      ey = $urandom_range(MAX_COORD);
    end
    span = (ex > sx) ? ex - sx : sx - ex;
    if (((ey > sy) ? ey - sy : sy - ey) > span)
      span = (ey > sy) ? ey - sy : sy - ey;
    pick = $urandom_range(99);
    if (pick < 15)
      step = 0;
    else if (pick < 30)
      step = span;
    else if (pick < 85)
      step = $urandom_range(span);
    else
      step = $urandom_range(MAX_COORD);
    drive_word(sx, sy, ex, ey, step, $urandom_range(16'hFFFF));
  endtask

  initial begin
    rst_ni         = 1'b0;
    start_i        = 1'b0;
    start_x_i      = '0;
    start_y_i      = '0;
    end_x_i        = '0;
    end_y_i        = '0;
    step_index_i   = '0;
    pixel_colour_i = '0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = REG_SCREEN_WIDTH;
    cfg_data_i     = '0;
    cur_w          = RESET_SCREEN_WIDTH;
    cur_h          = RESET_SCREEN_HEIGHT;
    idle_pct       = 12;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    drive_word(10, 10, 10, 10, 0, 16'hFFFF);
    drive_word(10, 10, 10, 10, 1, 16'h0000);
    drive_word(0, 5, 239, 5, 0, 16'hF800);
    drive_word(0, 5, 239, 5, 239, 16'h07E0);
    drive_word(239, 5, 0, 5, 240, 16'h001F);
    drive_word(7, 0, 7, 319, 319, 16'hAAAA);
    drive_word(0, 0, 100, 100, 50, 16'h5555);
    drive_word(200, 10, 50, 300, 100, 16'h1234);
    drive_word(230, 50, 10, 40, 5, 16'hFEDC);
    drive_word(MAX_COORD, MAX_COORD, 0, 0, 319, 16'h8001);
    drive_word(240, 0, 240, 320, 0, 16'h7FFE);
    drive_word(0, 0, 3, 10, 7, 16'h0F0F);
    drive_word(100, 300, 90, 0, 299, 16'hF0F0);
    drive_word(5, 5, 6, 300, MAX_COORD, 16'hFFFF);
    drive_word(0, 319, 239, 0, 120, 16'h3C3C);
    drive_word(MAX_COORD, 0, 0, MAX_COORD, 0, 16'h0000);
    drive_word(0, 0, 0, 0, 0, 16'h0000);
    drive_word(239, 319, 239, 319, 0, 16'hFFFF);
    drain();

    width_plan[5]  = $urandom_range(1024, 1);
    height_plan[5] = $urandom_range(1024, 1);
    for (int phase = 0; phase < PHASES; phase++) begin
      idle_pct = (phase < 3) ? 12 : (phase < 6) ? 61 : 0;
      set_screen(width_plan[phase], height_plan[phase], phase == 4);
      repeat (PHASE_WORDS) random_word();
      drain();
    end

    $display("Drove %0d line words over %0d screen settings, sizes 0 to 2047, with idle gaps.",
             words_sent, settings_used + 1);
    $display("Checked %0d points: single-point, axis-aligned, clamped and out-of-range steps.",
             checked_points);
    if (fail_count == 0 && pending_words == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
